// File: rtl/hds_pkg.sv
package hds_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] ChrLt     = 8'h3C;
  localparam logic [ByteW-1:0] ChrDash   = 8'h2D;
  localparam logic [ByteW-1:0] ChrSemi   = 8'h3B;
  localparam logic [ByteW-1:0] ChrPipe   = 8'h7C;
  localparam logic [ByteW-1:0] ChrAmp    = 8'h26;
  localparam logic [ByteW-1:0] ChrRParen = 8'h29;
  localparam logic [ByteW-1:0] ChrSQuote = 8'h27;
  localparam logic [ByteW-1:0] ChrDQuote = 8'h22;
  localparam logic [ByteW-1:0] ChrBslash = 8'h5C;
  localparam logic [ByteW-1:0] ChrSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChrTab    = 8'h09;
  localparam logic [ByteW-1:0] ChrCr     = 8'h0D;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] delim_byte;
    logic             byte_valid;
    logic             scan_done;
    logic             found;
    logic             tab_trim;
  } out_item_t;

endpackage

// File: rtl/hds_in_if.sv
interface hds_in_if;
  logic                     valid;
  logic                     ready;
  logic [hds_pkg::ByteW-1:0] in_byte;
  logic                     end_of_line;

  modport source (output valid, output in_byte, output end_of_line, input ready);
  modport sink (input valid, input in_byte, input end_of_line, output ready);
endinterface

// File: rtl/hds_out_if.sv
interface hds_out_if;
  logic                     valid;
  logic                     ready;
  logic [hds_pkg::ByteW-1:0] delim_byte;
  logic                     byte_valid;
  logic                     scan_done;
  logic                     found;
  logic                     tab_trim;

  modport source (output valid, output delim_byte, output byte_valid, output scan_done,
                  output found, output tab_trim, input ready);
  modport sink (input valid, input delim_byte, input byte_valid, input scan_done,
                input found, input tab_trim, output ready);
endinterface

// File: rtl/heredoc_delimiter_scanner.sv
// Heredoc delimiter scanner.
// The items channel carries one byte of a command line per request, and a
// request with end_of_line set closes the line. The results channel gives one
// request per delimiter byte, then one final request with scan_done set that
// tells whether a delimiter was found; tab_trim marks a "<<-" operator.
// Bytes that cause no result give no request.
// An accepted request is held in an input register, decoded against the scan
// state and written to the result register, from which its result is offered.
// One request can be accepted in every cycle while the receiver does not
// stall; the scan state is updated as each request leaves the input register.
// When the receiver stalls, the result register holds its request and the
// input register fills; items ready then falls until the result is taken.
// Reset empties both registers and returns the scanner to normal scanning;
// the scanner also returns there after every end of line.
module heredoc_delimiter_scanner (
  input logic      clk,
  input logic      rst,
  hds_in_if.sink   items,
  hds_out_if.source results
);

  typedef enum logic [2:0] {
    NORMAL, QSKIP, QESC, AFTEROP, BLANKS, QDELIM, UDELIM, DONE
  } mode_t;

  mode_t               mode, mode_next;
  logic [1:0]          lt_run, lt_run_next;
  logic                quote_is_double, quote_is_double_next;
  logic                tab_strip_seen, tab_strip_seen_next;
  logic                delim_nonempty, delim_nonempty_next;

  logic                s1_valid;
  hds_pkg::in_item_t   s1_item;
  logic                advance;

  logic                out_valid;
  hds_pkg::out_item_t  out_item;
  logic                emit;
  hds_pkg::out_item_t  res;

  assign advance     = s1_valid && (!out_valid || results.ready);
  assign items.ready = !s1_valid || advance;

  always_comb begin
    logic [hds_pkg::ByteW-1:0] c;
    logic is_quote, is_ws, is_term, close_q, op_path, blank_path, udelim_path;
    c         = s1_item.in_byte;
    is_quote  = (c == hds_pkg::ChrSQuote) || (c == hds_pkg::ChrDQuote);
    is_ws     = (c == hds_pkg::ChrSpace) || ((c >= hds_pkg::ChrTab) && (c <= hds_pkg::ChrCr));
    is_term   = is_ws || (c == hds_pkg::ChrSemi) || (c == hds_pkg::ChrPipe) ||
                (c == hds_pkg::ChrAmp) || (c == hds_pkg::ChrRParen);
    close_q   = quote_is_double ? (c == hds_pkg::ChrDQuote) : (c == hds_pkg::ChrSQuote);
    mode_next            = mode;
    lt_run_next          = lt_run;
    quote_is_double_next = quote_is_double;
    tab_strip_seen_next  = tab_strip_seen;
    delim_nonempty_next  = delim_nonempty;
    emit        = 1'b0;
    res         = '0;
    op_path     = 1'b0;
    blank_path  = 1'b0;
    udelim_path = 1'b0;

    if (s1_item.end_of_line) begin
      res.scan_done = 1'b1;
      emit          = (mode != DONE);
      case (mode)
        QDELIM:  res.found = 1'b1;
        UDELIM:  res.found = delim_nonempty;
        default: res.found = 1'b0;
      endcase
      res.tab_trim         = tab_strip_seen;
      mode_next            = NORMAL;
      lt_run_next          = '0;
      quote_is_double_next = 1'b0;
      tab_strip_seen_next  = 1'b0;
      delim_nonempty_next  = 1'b0;
    end else begin
      case (mode)
        NORMAL: begin
          if (c == hds_pkg::ChrLt) begin
            if (lt_run != 2'd2) begin
              lt_run_next = lt_run + 2'd1;
            end
          end else if (lt_run == 2'd2) begin
            lt_run_next = '0;
            op_path     = 1'b1;
          end else begin
            lt_run_next = '0;
            if (is_quote) begin
              quote_is_double_next = (c == hds_pkg::ChrDQuote);
              mode_next            = QSKIP;
            end
          end
        end
        QSKIP: begin
          if (quote_is_double && (c == hds_pkg::ChrBslash)) begin
            mode_next = QESC;
          end else if (close_q) begin
            mode_next = NORMAL;
          end
        end
        QESC: mode_next = QSKIP;
        AFTEROP: op_path = 1'b1;
        BLANKS: blank_path = 1'b1;
        QDELIM: begin
          emit = 1'b1;
          if (close_q) begin
            mode_next     = DONE;
            res.scan_done = 1'b1;
            res.found     = 1'b1;
          end else begin
            res.delim_byte = c;
            res.byte_valid = 1'b1;
          end
        end
        UDELIM: udelim_path = 1'b1;
        default: mode_next = mode;
      endcase

      if (op_path) begin
        mode_next = BLANKS;
        if (c == hds_pkg::ChrDash) begin
          tab_strip_seen_next = 1'b1;
        end else begin
          blank_path = 1'b1;
        end
      end
      if (blank_path) begin
        if ((c == hds_pkg::ChrSpace) || (c == hds_pkg::ChrTab)) begin
          mode_next = BLANKS;
        end else if (is_quote) begin
          quote_is_double_next = (c == hds_pkg::ChrDQuote);
          mode_next            = QDELIM;
        end else begin
          udelim_path = 1'b1;
        end
      end
      if (udelim_path) begin
        emit = 1'b1;
        if (is_term) begin
          mode_next     = DONE;
          res.scan_done = 1'b1;
          res.found     = delim_nonempty;
        end else begin
          mode_next           = UDELIM;
          delim_nonempty_next = 1'b1;
          res.delim_byte      = c;
          res.byte_valid      = 1'b1;
        end
      end
      res.tab_trim = tab_strip_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      mode            <= NORMAL;
      lt_run          <= '0;
      quote_is_double <= 1'b0;
      tab_strip_seen  <= 1'b0;
      delim_nonempty  <= 1'b0;
    end else begin
      if (items.ready) begin
        s1_valid <= items.valid;
      end
      if (advance) begin
        mode            <= mode_next;
        lt_run          <= lt_run_next;
        quote_is_double <= quote_is_double_next;
        tab_strip_seen  <= tab_strip_seen_next;
        delim_nonempty  <= delim_nonempty_next;
        out_valid       <= emit;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_item.in_byte     <= items.in_byte;
      s1_item.end_of_line <= items.end_of_line;
    end
    if (advance && emit) begin
      out_item <= res;
    end
  end

  assign results.valid      = out_valid;
  assign results.delim_byte = out_item.delim_byte;
  assign results.byte_valid = out_item.byte_valid;
  assign results.scan_done  = out_item.scan_done;
  assign results.found      = out_item.found;
  assign results.tab_trim   = out_item.tab_trim;

  a_byte_not_done: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !(results.byte_valid && results.scan_done))
    else $error("delimiter byte and final result in one request");

  a_found_only_done: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.found) |-> results.scan_done)
    else $error("found given without scan_done");

  a_lt_run_normal: assert property (@(posedge clk) disable iff (rst)
    (mode != NORMAL) |-> (lt_run == 2'd0))
    else $error("operator count held outside normal scanning");

  a_nonempty_mode: assert property (@(posedge clk) disable iff (rst)
    delim_nonempty |-> ((mode == UDELIM) || (mode == DONE)))
    else $error("delimiter marked non-empty outside delimiter scan");

endmodule
